FILE: hdl/priority_task_scheduler_with_timers_defines.svh
// Assertion macros shared by the scheduler checkers
`ifndef PRIORITY_TASK_SCHEDULER_WITH_TIMERS_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_TIMERS_DEFINES_SVH
// Check a property on every clock edge outside reset
`define PTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check that a trigger is followed in the next cycle by an expression
`define PTS_ASSERT_NEXT(lbl, trig, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);
`endif

FILE: hdl/ptsc_pkg.sv
// Shared constants, types and codes of the task scheduler
`default_nettype none
package ptsc_pkg;
   localparam int QUEUE_DEPTH  = 16;
   localparam int TIMER_DEPTH  = 16;
   localparam int CANCEL_DEPTH = 32;
   localparam int NUM_QUEUES   = 3;

   localparam int TAG_W    = 16;
   localparam int ID_W     = 24;
   localparam int ORD_W    = 24;
   localparam int TIME_W   = 48;
   localparam int DELAY_W  = 32;
   localparam int OP_W     = 3;
   localparam int PRIO_W   = 2;
   localparam int STATUS_W = 3;
   localparam int MAXP_W   = 6;
   localparam int MAXD_W   = 5;

   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int QADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int PEND_W  = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
   localparam int TIDX_W  = $clog2(TIMER_DEPTH);
   localparam int TCNT_W  = $clog2(TIMER_DEPTH + 1);
   localparam int CIDX_W  = $clog2(CANCEL_DEPTH);
   localparam int CCNT_W  = $clog2(CANCEL_DEPTH + 1);

   typedef logic [1:0] qsel_type;
   localparam qsel_type QUEUE_HIGH   = 2'd0;
   localparam qsel_type QUEUE_NORMAL = 2'd1;
   localparam qsel_type QUEUE_LOW    = 2'd2;

   localparam logic CSR_MAX_PENDING = 1'b0;
   localparam logic CSR_MAX_DELAYED = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_POST                = 3'd0,
      OP_POST_DELAYED        = 3'd1,
      OP_POST_CANCEL         = 3'd2,
      OP_POST_CANCEL_DELAYED = 3'd3,
      OP_CANCEL              = 3'd4,
      OP_FETCH               = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED      = 3'd0,
      ST_REJECTED      = 3'd1,
      ST_DISPATCHED    = 3'd2,
      ST_IDLE          = 3'd3,
      ST_CANCEL_DONE   = 3'd4,
      ST_CANCEL_REFUSE = 3'd5,
      ST_CANCEL_FULL   = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CLOOK, S_TSCAN, S_TCAN, S_TDUE, S_HRD, S_HCMP,
      S_HSEL, S_HCAN, S_QRD, S_QPOP, S_QCAN, S_DONE
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [ID_W-1:0]  id;
      logic [ORD_W-1:0] order;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] fire;
      entry_type         ent;
   } timer_rec_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [TIDX_W-1:0] idx;
      timer_rec_type     rec;
   } tscan_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } clook_type;
endpackage
`default_nettype wire

FILE: hdl/ptsc_fifo_store.sv
// Three priority FIFOs sharing one entry memory, with head and count pointers
`default_nettype none
module ptsc_fifo_store import ptsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  qsel_type          sel_q,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic              pop,
   output entry_type         head_entry,
   output logic [QCNT_W-1:0] sel_count,
   output logic [PEND_W-1:0] total_count
);
   entry_type         mem_ff [NUM_QUEUES * QUEUE_DEPTH];
   entry_type         rd_ff;
   logic [QPTR_W-1:0] head_ff [NUM_QUEUES];
   logic [QPTR_W-1:0] head_in [NUM_QUEUES];
   logic [QCNT_W-1:0] cnt_ff  [NUM_QUEUES];
   logic [QCNT_W-1:0] cnt_in  [NUM_QUEUES];
   logic [QPTR_W-1:0] sel_head;
   logic [QCNT_W:0]   tail_sum;
   logic [QPTR_W-1:0] tail;
   logic [QPTR_W-1:0] slot;
   logic [QADDR_W-1:0] addr;

   // Locate head and tail of the selected queue
   always_comb begin
      sel_head  = head_ff[sel_q];
      sel_count = cnt_ff[sel_q];
      tail_sum  = (QCNT_W+1)'(sel_head) + (QCNT_W+1)'(sel_count);
      if (tail_sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (QCNT_W+1)'(QUEUE_DEPTH);
      end
      tail = tail_sum[QPTR_W-1:0];
      slot = push ? tail : sel_head;
      addr = QADDR_W'(sel_q * QUEUE_DEPTH) + QADDR_W'(slot);
   end

   // Advance pointers on push and pop
   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         cnt_in[sel_q] = sel_count + 1'b1;
      end else if (pop) begin
         cnt_in[sel_q]  = sel_count - 1'b1;
         head_in[sel_q] = (sel_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
      end
   end

   // Sum the fill levels
   always_comb begin
      total_count = '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         total_count = total_count + PEND_W'(cnt_ff[q]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[addr] <= push_entry;
      end
      rd_ff <= mem_ff[addr];
   end

   assign head_entry = rd_ff;
endmodule
`default_nettype wire

FILE: hdl/ptsc_timer_store.sv
// Timer store: record memory, valid bits and a scan for the earliest timer
`default_nettype none
module ptsc_timer_store import ptsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  timer_rec_type     wr_rec,
   input  logic              clr_en,
   input  logic [TIDX_W-1:0] clr_idx,
   input  logic              scan_start,
   output tscan_type         scan,
   output logic              free_found,
   output logic [TCNT_W-1:0] count
);
   localparam logic [TIDX_W:0] SCAN_END = (TIDX_W+1)'(TIMER_DEPTH);

   timer_rec_type          mem_ff [TIMER_DEPTH];
   timer_rec_type          rd_ff;
   logic [TIMER_DEPTH-1:0] valid_ff, valid_in;
   logic [TCNT_W-1:0]      count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic [TIDX_W:0]        sidx_ff, sidx_in;
   logic                   cvld_ff, cvld_in;
   logic [TIDX_W-1:0]      cidx_ff, cidx_in;
   logic                   done_ff, done_in;
   logic                   found_ff, found_in;
   logic [TIDX_W-1:0]      bidx_ff, bidx_in;
   timer_rec_type          brec_ff, brec_in;
   logic [TIDX_W-1:0]      free_idx;
   logic                   better;

   // Find the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = TIDX_W'(i);
         end
      end
   end

   // Set and drop valid bits
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (wr_en) begin
         valid_in[free_idx] = 1'b1;
         count_in           = count_ff + 1'b1;
      end else if (clr_en) begin
         valid_in[clr_idx] = 1'b0;
         count_in          = count_ff - 1'b1;
      end
   end

   // Walk the store one entry a cycle, keeping the earliest (fire, order)
   always_comb begin
      better = (rd_ff.fire < brec_ff.fire) ||
               ((rd_ff.fire == brec_ff.fire) && (rd_ff.ent.order < brec_ff.ent.order));
      busy_in  = busy_ff;
      sidx_in  = sidx_ff;
      cvld_in  = 1'b0;
      cidx_in  = cidx_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      bidx_in  = bidx_ff;
      brec_in  = brec_ff;
      if (scan_start) begin
         busy_in  = 1'b1;
         sidx_in  = '0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (sidx_ff == SCAN_END) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cvld_in = 1'b1;
            cidx_in = sidx_ff[TIDX_W-1:0];
            sidx_in = sidx_ff + 1'b1;
         end
      end
      if (cvld_ff && valid_ff[cidx_ff] && (!found_ff || better)) begin
         found_in = 1'b1;
         bidx_in  = cidx_ff;
         brec_in  = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         busy_ff  <= 1'b0;
         sidx_ff  <= '0;
         cvld_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
         sidx_ff  <= sidx_in;
         cvld_ff  <= cvld_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff <= cidx_in;
      bidx_ff <= bidx_in;
      brec_ff <= brec_in;
   end

   // Record memory: write into the free slot, read at the scan index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[free_idx] <= wr_rec;
      end
      rd_ff <= mem_ff[sidx_ff[TIDX_W-1:0]];
   end

   assign scan.done  = done_ff;
   assign scan.found = found_ff;
   assign scan.idx   = bidx_ff;
   assign scan.rec   = brec_ff;
   assign count      = count_ff;
endmodule
`default_nettype wire

FILE: hdl/ptsc_cancel_set.sv
// Cancelled id set: filled in order, searched one entry a cycle
`default_nettype none
module ptsc_cancel_set import ptsc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            look_start,
   input  logic [ID_W-1:0] key,
   input  logic            ins_en,
   output clook_type       res
);
   logic [ID_W-1:0]   mem_ff [CANCEL_DEPTH];
   logic [ID_W-1:0]   rd_ff;
   logic [CCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [CCNT_W-1:0] sidx_ff, sidx_in;
   logic              cvld_ff, cvld_in;
   logic              done_ff, done_in;
   logic              hit_ff, hit_in;

   // Compare each recorded id against the key
   always_comb begin
      cnt_in  = ins_en ? cnt_ff + 1'b1 : cnt_ff;
      busy_in = busy_ff;
      sidx_in = sidx_ff;
      cvld_in = 1'b0;
      done_in = 1'b0;
      hit_in  = hit_ff;
      if (look_start) begin
         busy_in = 1'b1;
         sidx_in = '0;
         hit_in  = 1'b0;
      end else if (busy_ff) begin
         if (sidx_ff == cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cvld_in = 1'b1;
            sidx_in = sidx_ff + 1'b1;
         end
      end
      if (cvld_ff && (rd_ff == key)) begin
         hit_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         sidx_ff <= '0;
         cvld_ff <= 1'b0;
         done_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         sidx_ff <= sidx_in;
         cvld_ff <= cvld_in;
         done_ff <= done_in;
         hit_ff  <= hit_in;
      end
   end

   // Id memory: append at the fill count, read at the search index
   always_ff @(posedge clock) begin
      if (ins_en) begin
         mem_ff[cnt_ff[CIDX_W-1:0]] <= key;
      end
      rd_ff <= mem_ff[sidx_ff[CIDX_W-1:0]];
   end

   assign res.done = done_ff;
   assign res.hit  = hit_ff;
   assign res.full = (cnt_ff == CCNT_W'(CANCEL_DEPTH));
endmodule
`default_nettype wire

FILE: hdl/priority_task_scheduler_with_timers.sv
// A post passes from decode to the done state and the output register; a cancel first searches the cancel set.
// Fetch: a timer scan over the whole timer store, repeated when a cancelled entry is dropped,
//   a search of the cancel set for each entry checked that carries an id, and a compare of the FIFO heads.
// One transaction at a time; the next is taken as soon as the result sits in the output register.
// Synchronous reset: FIFOs and timer store empty, cancel set empty, order 0, next id 1.
// Memories are never cleared; fill counts and valid bits stand for their reset contents.
`default_nettype none
module priority_task_scheduler_with_timers import ptsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [TAG_W-1:0]    req_task_tag,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [DELAY_W-1:0]  req_delay_ms,
   input  logic [ID_W-1:0]     req_cancel_id,
   input  logic [TIME_W-1:0]   req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [TAG_W-1:0]    rsp_out_tag,
   output logic [ID_W-1:0]     rsp_assigned_id,
   output logic [DELAY_W-1:0]  rsp_wait_ms,
   output logic [MAXP_W-1:0]   rsp_pending_count,
   output logic [MAXD_W-1:0]   rsp_delayed_count,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [MAXP_W-1:0]   csr_wdata
);
   localparam int CMPP_W = (PEND_W > MAXP_W) ? PEND_W : MAXP_W;
   localparam int CMPD_W = (TCNT_W > MAXD_W) ? TCNT_W : MAXD_W;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [ID_W-1:0]    cid_ff, cid_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [MAXP_W-1:0]  maxp_ff, maxp_in;
   logic [MAXD_W-1:0]  maxd_ff, maxd_in;
   logic [ORD_W-1:0]   order_ff, order_in;
   logic [ID_W-1:0]    id_ff, id_in;
   status_type         st_ff, st_in;
   logic [TAG_W-1:0]   otag_ff, otag_in;
   logic [ID_W-1:0]    aid_ff, aid_in;
   logic [DELAY_W-1:0] wait_ff, wait_in;
   qsel_type           hq_ff, hq_in;
   logic               hb_found_ff, hb_found_in;
   qsel_type           hb_q_ff, hb_q_in;
   entry_type          hb_ent_ff, hb_ent_in;
   logic [ID_W-1:0]    key_ff, key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [ID_W-1:0]     rsp_aid_ff, rsp_aid_in;
   logic [DELAY_W-1:0]  rsp_wait_ff, rsp_wait_in;
   logic [MAXP_W-1:0]   rsp_pend_ff, rsp_pend_in;
   logic [MAXD_W-1:0]   rsp_dly_ff, rsp_dly_in;

   qsel_type          f_sel_q;
   logic              f_push, f_pop;
   entry_type         f_push_entry, f_head;
   logic [QCNT_W-1:0] f_sel_count;
   logic [PEND_W-1:0] f_total;

   logic              t_wr, t_clr, t_start, t_free;
   timer_rec_type     t_wr_rec;
   tscan_type         t_scan;
   logic [TCNT_W-1:0] t_count;

   logic      c_start, c_ins;
   clook_type c_res;

   logic              accept;
   qsel_type          post_q;
   logic [ID_W-1:0]   id_next;
   logic [TIME_W:0]   fire_sum;
   logic [TIME_W-1:0] fire;
   logic [TIME_W-1:0] diff;
   logic              due;
   logic              pend_full, dly_full;

   ptsc_fifo_store u_fifo (
      .clock       (clock),
      .reset       (reset),
      .sel_q       (f_sel_q),
      .push        (f_push),
      .push_entry  (f_push_entry),
      .pop         (f_pop),
      .head_entry  (f_head),
      .sel_count   (f_sel_count),
      .total_count (f_total)
   );

   ptsc_timer_store u_timer (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (t_wr),
      .wr_rec     (t_wr_rec),
      .clr_en     (t_clr),
      .clr_idx    (t_scan.idx),
      .scan_start (t_start),
      .scan       (t_scan),
      .free_found (t_free),
      .count      (t_count)
   );

   ptsc_cancel_set u_cancel (
      .clock      (clock),
      .reset      (reset),
      .look_start (c_start),
      .key        (key_ff),
      .ins_en     (c_ins),
      .res        (c_res)
   );

   // Shared arithmetic for posts and fetches
   always_comb begin
      accept   = req_valid && (state_ff == S_IDLE);
      id_next  = (id_ff == '1) ? ID_W'(1) : id_ff + 1'b1;
      fire_sum = (TIME_W+1)'(now_ff) + (TIME_W+1)'(delay_ff);
      fire     = fire_sum[TIME_W] ? '1 : fire_sum[TIME_W-1:0];
      diff     = t_scan.rec.fire - now_ff;
      due      = (now_ff >= t_scan.rec.fire);
      if (op_ff == OP_POST_CANCEL) begin
         post_q = QUEUE_NORMAL;
      end else if (prio_ff == PRIO_W'(QUEUE_HIGH)) begin
         post_q = QUEUE_HIGH;
      end else if (prio_ff == PRIO_W'(QUEUE_NORMAL)) begin
         post_q = QUEUE_NORMAL;
      end else begin
         post_q = QUEUE_LOW;
      end
      pend_full = (maxp_ff != '0) && (CMPP_W'(f_total) >= CMPP_W'(maxp_ff));
      dly_full  = (maxd_ff != '0) && (CMPD_W'(t_count) >= CMPD_W'(maxd_ff));
   end

   // Sequencer: next state, datapath updates and store controls
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      tag_in      = tag_ff;
      prio_in     = prio_ff;
      delay_in    = delay_ff;
      cid_in      = cid_ff;
      now_in      = now_ff;
      maxp_in     = maxp_ff;
      maxd_in     = maxd_ff;
      order_in    = order_ff;
      id_in       = id_ff;
      st_in       = st_ff;
      otag_in     = otag_ff;
      aid_in      = aid_ff;
      wait_in     = wait_ff;
      hq_in       = hq_ff;
      hb_found_in = hb_found_ff;
      hb_q_in     = hb_q_ff;
      hb_ent_in   = hb_ent_ff;
      key_in      = key_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_aid_in    = rsp_aid_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_dly_in    = rsp_dly_ff;

      f_sel_q      = hq_ff;
      f_push       = 1'b0;
      f_pop        = 1'b0;
      f_push_entry = '{tag: tag_ff, id: '0, order: order_ff};
      t_wr         = 1'b0;
      t_clr        = 1'b0;
      t_start      = 1'b0;
      t_wr_rec     = '{fire: fire, ent: '{tag: tag_ff, id: '0, order: order_ff + 1'b1}};
      c_start      = 1'b0;
      c_ins        = 1'b0;

      // Take register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_PENDING: maxp_in = csr_wdata;
            CSR_MAX_DELAYED: maxd_in = csr_wdata[MAXD_W-1:0];
            default:         maxp_in = maxp_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               tag_in   = req_task_tag;
               prio_in  = req_priority_req;
               delay_in = req_delay_ms;
               cid_in   = req_cancel_id;
               now_in   = req_now_ms;
               st_in    = ST_IDLE;
               otag_in  = '0;
               aid_in   = '0;
               wait_in  = '0;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_DONE;
            unique case (op_ff)
               OP_POST, OP_POST_CANCEL: begin
                  f_sel_q = post_q;
                  otag_in = tag_ff;
                  if (pend_full || (f_sel_count == QCNT_W'(QUEUE_DEPTH))) begin
                     st_in = ST_REJECTED;
                  end else begin
                     f_push   = 1'b1;
                     order_in = order_ff + 1'b1;
                     st_in    = ST_ACCEPTED;
                     if (op_ff == OP_POST_CANCEL) begin
                        f_push_entry.id = id_ff;
                        aid_in          = id_ff;
                        id_in           = id_next;
                     end
                  end
               end
               OP_POST_DELAYED, OP_POST_CANCEL_DELAYED: begin
                  otag_in = tag_ff;
                  if (dly_full || !t_free) begin
                     st_in = ST_REJECTED;
                  end else begin
                     t_wr     = 1'b1;
                     order_in = order_ff + 1'b1;
                     st_in    = ST_ACCEPTED;
                     if (op_ff == OP_POST_CANCEL_DELAYED) begin
                        t_wr_rec.ent.id = id_ff;
                        aid_in          = id_ff;
                        id_in           = id_next;
                     end
                  end
               end
               OP_CANCEL: begin
                  if (cid_ff == '0) begin
                     st_in = ST_CANCEL_REFUSE;
                  end else begin
                     key_in   = cid_ff;
                     c_start  = 1'b1;
                     state_in = S_CLOOK;
                  end
               end
               OP_FETCH: begin
                  t_start  = 1'b1;
                  state_in = S_TSCAN;
               end
               default: st_in = ST_IDLE;
            endcase
         end

         S_CLOOK: begin
            if (c_res.done) begin
               state_in = S_DONE;
               priority if (c_res.hit) begin
                  st_in = ST_CANCEL_REFUSE;
               end else if (c_res.full) begin
                  st_in = ST_CANCEL_FULL;
               end else begin
                  c_ins = 1'b1;
                  st_in = ST_CANCEL_DONE;
               end
            end
         end

         // Earliest timer, then drop it if cancelled
         S_TSCAN: begin
            if (t_scan.done) begin
               hq_in = QUEUE_HIGH;
               priority if (!t_scan.found) begin
                  state_in = S_QRD;
               end else if (t_scan.rec.ent.id == '0) begin
                  state_in = S_TDUE;
               end else begin
                  key_in   = t_scan.rec.ent.id;
                  c_start  = 1'b1;
                  state_in = S_TCAN;
               end
            end
         end

         S_TCAN: begin
            if (c_res.done) begin
               if (c_res.hit) begin
                  t_clr    = 1'b1;
                  t_start  = 1'b1;
                  state_in = S_TSCAN;
               end else begin
                  state_in = S_TDUE;
               end
            end
         end

         S_TDUE: begin
            hq_in       = QUEUE_HIGH;
            hb_found_in = 1'b0;
            if (due) begin
               state_in = S_HRD;
            end else begin
               wait_in  = (diff[TIME_W-1:DELAY_W] != '0) ? '1 : diff[DELAY_W-1:0];
               state_in = S_QRD;
            end
         end

         // Read the FIFO heads to find the oldest one
         S_HRD: begin
            priority if (f_sel_count != '0) begin
               state_in = S_HCMP;
            end else if (hq_ff == QUEUE_LOW) begin
               state_in = S_HSEL;
            end else begin
               hq_in = hq_ff + 1'b1;
            end
         end

         S_HCMP: begin
            if (!hb_found_ff || (f_head.order < hb_ent_ff.order)) begin
               hb_found_in = 1'b1;
               hb_q_in     = hq_ff;
               hb_ent_in   = f_head;
            end
            if (hq_ff == QUEUE_LOW) begin
               state_in = S_HSEL;
            end else begin
               hq_in    = hq_ff + 1'b1;
               state_in = S_HRD;
            end
         end

         // Older FIFO head beats the due timer; ties go to the timer
         S_HSEL: begin
            f_sel_q = hb_q_ff;
            if (hb_found_ff && (hb_ent_ff.order < t_scan.rec.ent.order)) begin
               f_pop = 1'b1;
               if (hb_ent_ff.id == '0) begin
                  st_in    = ST_DISPATCHED;
                  otag_in  = hb_ent_ff.tag;
                  state_in = S_DONE;
               end else begin
                  key_in   = hb_ent_ff.id;
                  c_start  = 1'b1;
                  state_in = S_HCAN;
               end
            end else begin
               t_clr    = 1'b1;
               st_in    = ST_DISPATCHED;
               otag_in  = t_scan.rec.ent.tag;
               state_in = S_DONE;
            end
         end

         S_HCAN: begin
            if (c_res.done) begin
               if (c_res.hit) begin
                  t_start  = 1'b1;
                  state_in = S_TSCAN;
               end else begin
                  st_in    = ST_DISPATCHED;
                  otag_in  = hb_ent_ff.tag;
                  wait_in  = '0;
                  state_in = S_DONE;
               end
            end
         end

         // Strict priority drain, skipping cancelled entries
         S_QRD: begin
            priority if (f_sel_count != '0) begin
               state_in = S_QPOP;
            end else if (hq_ff == QUEUE_LOW) begin
               st_in    = ST_IDLE;
               state_in = S_DONE;
            end else begin
               hq_in = hq_ff + 1'b1;
            end
         end

         S_QPOP: begin
            f_pop     = 1'b1;
            hb_ent_in = f_head;
            if (f_head.id == '0) begin
               st_in    = ST_DISPATCHED;
               otag_in  = f_head.tag;
               wait_in  = '0;
               state_in = S_DONE;
            end else begin
               key_in   = f_head.id;
               c_start  = 1'b1;
               state_in = S_QCAN;
            end
         end

         S_QCAN: begin
            if (c_res.done) begin
               if (c_res.hit) begin
                  state_in = S_QRD;
               end else begin
                  st_in    = ST_DISPATCHED;
                  otag_in  = hb_ent_ff.tag;
                  wait_in  = '0;
                  state_in = S_DONE;
               end
            end
         end

         // Hand the transaction to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_tag_in    = otag_ff;
               rsp_aid_in    = aid_ff;
               rsp_wait_in   = (st_ff == ST_DISPATCHED) ? '0 : wait_ff;
               rsp_pend_in   = MAXP_W'(f_total);
               rsp_dly_in    = MAXD_W'(t_count);
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         maxp_ff      <= '0;
         maxd_ff      <= '0;
         order_ff     <= '0;
         id_ff        <= ID_W'(1);
         hb_found_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         maxp_ff      <= maxp_in;
         maxd_ff      <= maxd_in;
         order_ff     <= order_in;
         id_ff        <= id_in;
         hb_found_ff  <= hb_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      prio_ff       <= prio_in;
      delay_ff      <= delay_in;
      cid_ff        <= cid_in;
      now_ff        <= now_in;
      st_ff         <= st_in;
      otag_ff       <= otag_in;
      aid_ff        <= aid_in;
      wait_ff       <= wait_in;
      hq_ff         <= hq_in;
      hb_q_ff       <= hb_q_in;
      hb_ent_ff     <= hb_ent_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_aid_ff    <= rsp_aid_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_dly_ff    <= rsp_dly_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_tag       = rsp_tag_ff;
   assign rsp_assigned_id   = rsp_aid_ff;
   assign rsp_wait_ms       = rsp_wait_ff;
   assign rsp_pending_count = rsp_pend_ff;
   assign rsp_delayed_count = rsp_dly_ff;
endmodule
`default_nettype wire

FILE: hdl/ptsc_checker.sv
// Port-level checks of the task scheduler and their binding
`default_nettype none
`include "priority_task_scheduler_with_timers_defines.svh"
module ptsc_checker import ptsc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [TAG_W-1:0]    rsp_out_tag,
   input logic [ID_W-1:0]     rsp_assigned_id,
   input logic [DELAY_W-1:0]  rsp_wait_ms
);
   // One transaction at a time: intake closes right after an accept
   `PTS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
                    "accepted twice in a row")
   // A stalled result holds
   `PTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag),
                    "stalled result changed")
   // Ids come only with accepted posts
   `PTS_ASSERT(a_id_on_post,
               (rsp_valid && rsp_assigned_id != '0) |-> (rsp_status == ST_ACCEPTED),
               "id on non-post result")
   // Wait time only on an idle fetch
   `PTS_ASSERT(a_wait_on_idle,
               (rsp_valid && rsp_wait_ms != '0) |-> (rsp_status == ST_IDLE),
               "wait on non-idle result")
endmodule

bind priority_task_scheduler_with_timers ptsc_checker u_ptsc_checker (.*);
`default_nettype wire
